FILE: rtl/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared constants, register codes and bundle types for the 3x3 zero-padded
// convolution block.
// ----------------------------------------------------------------------------
package c3zp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_COLS_DEF    = 1024;
    localparam int PIXEL_BITS_DEF  = 8;
    localparam int WEIGHT_BITS_DEF = 8;

    // Kernel and frame geometry.
    localparam int KSIZE          = 3;
    localparam int ROW_LIMIT      = 4096;
    localparam int ROW_CNT_W      = 13;
    localparam int COLS_REG_W     = 11;
    localparam int ROWS_REG_W     = 13;
    localparam int KROW_W         = 24;
    localparam int FRAME_COLS_RST = 1024;
    localparam int FRAME_ROWS_RST = 1024;

    // Configuration port.
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Result fields.
    localparam int RESP_W    = 20;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 10;

    // Result queue depth; must be a power of two.
    localparam int OFIFO_DEPTH = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS    = 3'd0,
        REG_FRAME_ROWS    = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MID    = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } t_reg_idx;

    // Per-result control that travels alongside the window pipeline.
    typedef struct packed {
        logic                 mtop;
        logic                 mbot;
        logic                 mleft;
        logic                 mright;
        logic                 frame_end;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } t_ctrl;

    // Border masking seen by one window column cell.
    typedef struct packed {
        logic mtop;
        logic mbot;
        logic mcol;
    } t_cell_mask;

    // One finished result.
    typedef struct packed {
        logic signed [RESP_W-1:0] response;
        logic [OUT_ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0]     col;
        logic                     frame_end;
    } t_result;

endpackage

FILE: rtl/c3zp_cell.sv
// ----------------------------------------------------------------------------
// c3zp_cell
// One column of the 3x3 window: holds three pixels, hands them to the next
// column on every shift, and forms the masked weighted sum of its column.
// ----------------------------------------------------------------------------
module c3zp_cell #(
    parameter int PIXEL_BITS  = c3zp_pkg::PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = c3zp_pkg::WEIGHT_BITS_DEF,
    localparam int PROD_W     = PIXEL_BITS + WEIGHT_BITS + 1,
    localparam int COL_W      = PROD_W + 2
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_shift,
    input  logic [c3zp_pkg::KSIZE-1:0][PIXEL_BITS-1:0]      i_col,
    input  logic [c3zp_pkg::KSIZE-1:0][WEIGHT_BITS-1:0]     i_weight,
    input  c3zp_pkg::t_cell_mask                            i_mask,
    output logic [c3zp_pkg::KSIZE-1:0][PIXEL_BITS-1:0]      o_col,
    output logic signed [COL_W-1:0]                         o_sum
);

    logic [c3zp_pkg::KSIZE-1:0][PIXEL_BITS-1:0] r_pix;
    logic signed [PROD_W-1:0] r_prod [c3zp_pkg::KSIZE];
    logic signed [PROD_W-1:0] n_prod [c3zp_pkg::KSIZE];
    logic signed [COL_W-1:0]  r_sum;
    logic signed [COL_W-1:0]  n_sum;

    // Pixel column, shifted in from the newer neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_col;
        end
    end

    // Products, zeroed where the tap falls outside the frame.
    always_comb begin
        for (int k = 0; k < c3zp_pkg::KSIZE; k++) begin
            if (i_mask.mcol || (k == 0 && i_mask.mtop)
                    || (k == c3zp_pkg::KSIZE - 1 && i_mask.mbot)) begin
                n_prod[k] = '0;
            end else begin
                n_prod[k] = $signed({1'b0, r_pix[k]}) * $signed(i_weight[k]);
            end
        end
    end

    // Column sum of the registered products.
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < c3zp_pkg::KSIZE; k++) begin
            n_sum = n_sum + COL_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < c3zp_pkg::KSIZE; k++) begin
            r_prod[k] <= n_prod[k];
        end
        r_sum <= n_sum;
    end

    assign o_col = r_pix;
    assign o_sum = r_sum;

endmodule

FILE: rtl/c3zp_lines.sv
// ----------------------------------------------------------------------------
// c3zp_lines
// The two line stores, kept as one memory with an older and a newer pixel per
// column. Each transfer reads its column and writes it back in the next cycle.
// ----------------------------------------------------------------------------
module c3zp_lines #(
    parameter int MAX_COLS   = c3zp_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = c3zp_pkg::PIXEL_BITS_DEF,
    localparam int ADDR_W    = $clog2(MAX_COLS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_top,
    output logic [PIXEL_BITS-1:0] o_mid,
    output logic [PIXEL_BITS-1:0] o_pixel
);

    logic [2*PIXEL_BITS-1:0] mem [MAX_COLS];
    logic [2*PIXEL_BITS-1:0] r_rd;
    logic [2*PIXEL_BITS-1:0] r_fwd_data;
    logic [2*PIXEL_BITS-1:0] rd_word;
    logic [2*PIXEL_BITS-1:0] wr_word;
    logic [ADDR_W-1:0]       r_addr;
    logic [PIXEL_BITS-1:0]   r_px;
    logic                    r_valid;
    logic                    r_fwd;

    // Read this cycle's column; write back the previous transfer's column.
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_addr];
        if (r_valid) begin
            mem[r_addr] <= wr_word;
        end
        r_fwd_data <= wr_word;
        r_addr     <= i_addr;
        r_px       <= i_pixel;
    end

    // Back-to-back transfers at the same column take the word being written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_valid <= i_rd_en;
            r_fwd   <= i_rd_en && r_valid && (i_addr == r_addr);
        end
    end

    // The newer pixel moves to the older store, the new pixel to the newer.
    assign rd_word = r_fwd ? r_fwd_data : r_rd;
    assign o_top   = rd_word[2*PIXEL_BITS-1:PIXEL_BITS];
    assign o_mid   = rd_word[PIXEL_BITS-1:0];
    assign o_pixel = r_px;
    assign o_valid = r_valid;
    assign wr_word = {o_mid, r_px};

endmodule

FILE: rtl/c3zp_ofifo.sv
// ----------------------------------------------------------------------------
// c3zp_ofifo
// Small result queue that decouples the output stall from the pipeline.
// ----------------------------------------------------------------------------
module c3zp_ofifo #(
    localparam int DEPTH = c3zp_pkg::OFIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c3zp_pkg::t_result   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output c3zp_pkg::t_result   o_data,
    output logic [CNT_W-1:0]    o_count
);

    c3zp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              pop;

    assign pop = o_valid && !i_stall;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Occupancy follows pushes and completed transfers.
    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: rtl/conv3x3_zero_padded.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded
// Streaming 3x3 convolution with zero padding. Pixels enter in raster order,
// one per transfer, and each gives one signed response: the 3x3 neighborhood
// times the kernel as written, with taps outside the frame counted as zero.
// A response appears after the transfer that completes its neighborhood, one
// row plus one pixel after its center; drain transfers (req_type 1) after the
// last pixel push out the rest, and the result carrying frame_end ends the
// frame. The block takes one transfer per clock while o_stall is low. A row of
// three column cells holds the window and does the nine multiplies, and one
// memory with a single read and a single write per cycle holds both line
// stores. An eight-entry result queue sits at the output; the input stalls
// only when queued plus in-flight results would fill it. No clearing pass is
// needed after reset. Frame size writes restart the frame; the user must write
// configuration only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded #(
    parameter int MAX_COLS    = c3zp_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS  = c3zp_pkg::PIXEL_BITS_DEF,
    parameter int WEIGHT_BITS = c3zp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_req_type,
    input  logic [PIXEL_BITS-1:0]                 i_pixel,
    // Output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [c3zp_pkg::RESP_W-1:0]    o_response,
    output logic [c3zp_pkg::OUT_ROW_W-1:0]        o_out_row,
    output logic [c3zp_pkg::OUT_COL_W-1:0]        o_out_col,
    output logic                                  o_frame_end,
    // Configuration port
    input  logic                                  i_cfg_wr_en,
    input  logic [c3zp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [c3zp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int KSIZE   = c3zp_pkg::KSIZE;
    localparam int ADDR_W  = $clog2(MAX_COLS);
    localparam int CNT_W   = $clog2(MAX_COLS + 1);
    localparam int RCNT_W  = c3zp_pkg::ROW_CNT_W;
    localparam int PROD_W  = PIXEL_BITS + WEIGHT_BITS + 1;
    localparam int COL_W   = PROD_W + 2;
    localparam int SUM_W   = COL_W + 2;
    localparam int KEXT_W  = (KSIZE * WEIGHT_BITS > c3zp_pkg::KROW_W)
                             ? KSIZE * WEIGHT_BITS : c3zp_pkg::KROW_W;
    localparam int COLS_RST = (c3zp_pkg::FRAME_COLS_RST > MAX_COLS)
                              ? MAX_COLS : c3zp_pkg::FRAME_COLS_RST;
    localparam int STAGES  = 4;
    localparam int QCNT_W  = $clog2(c3zp_pkg::OFIFO_DEPTH + 1);
    localparam int OCC_W   = QCNT_W + 1;

    // Configuration and frame counters.
    logic [CNT_W-1:0]                r_cols,    n_cols;
    logic [ADDR_W-1:0]               r_cols_m1, n_cols_m1;
    logic [RCNT_W-1:0]               r_rows,    n_rows;
    logic [c3zp_pkg::OUT_ROW_W-1:0]  r_rows_m1, n_rows_m1;
    logic [c3zp_pkg::KROW_W-1:0]     r_krow [KSIZE];
    logic [c3zp_pkg::KROW_W-1:0]     n_krow [KSIZE];
    logic [RCNT_W-1:0]               r_ir, n_ir;
    logic [ADDR_W-1:0]               r_ic, n_ic;

    // Front-end decode.
    logic                  accept;
    logic                  beyond;
    logic                  active;
    logic                  emit;
    logic                  ic_zero;
    logic [PIXEL_BITS-1:0] px_eff;
    logic [RCNT_W-1:0]     orow;
    logic [ADDR_W-1:0]     ocol;
    c3zp_pkg::t_ctrl       ctrl;

    // Frame size write helpers.
    logic [c3zp_pkg::COLS_REG_W-1:0] cfg_cols;
    logic [c3zp_pkg::ROWS_REG_W-1:0] cfg_rows;
    logic [CNT_W-1:0]                cols_clamped;
    logic [RCNT_W-1:0]               rows_clamped;

    // Pipeline control.
    logic            r_ev   [STAGES];
    c3zp_pkg::t_ctrl r_ctrl [STAGES];
    logic [OCC_W-1:0] inflight;
    logic [OCC_W-1:0] occupancy;
    logic [QCNT_W-1:0] q_count;

    // Line store and window.
    logic                  ln_valid;
    logic [PIXEL_BITS-1:0] ln_top;
    logic [PIXEL_BITS-1:0] ln_mid;
    logic [PIXEL_BITS-1:0] ln_px;
    logic [KSIZE-1:0][PIXEL_BITS-1:0] cell_in  [KSIZE];
    logic [KSIZE-1:0][PIXEL_BITS-1:0] cell_out [KSIZE];
    logic signed [COL_W-1:0]          cell_sum [KSIZE];
    logic [KEXT_W-1:0]                krow_ext [KSIZE];

    logic signed [SUM_W-1:0] total;
    c3zp_pkg::t_result       result;
    c3zp_pkg::t_result       q_data;

    // Input transfer and pixel decode; drain ticks inside the frame do nothing.
    assign accept  = i_valid && !o_stall;
    assign beyond  = (r_ir >= r_rows);
    assign active  = beyond || !i_req_type;
    assign px_eff  = beyond ? '0 : i_pixel;
    assign ic_zero = (r_ic == '0);
    assign emit    = (r_ir >= RCNT_W'(2)) || ((r_ir == RCNT_W'(1)) && !ic_zero);

    // Position of the result this transfer completes, and its border masks.
    always_comb begin
        orow = ic_zero ? (r_ir - RCNT_W'(2)) : (r_ir - RCNT_W'(1));
        ocol = ic_zero ? r_cols_m1 : (r_ic - ADDR_W'(1));
        ctrl.mtop      = (orow == '0);
        ctrl.mbot      = (orow == RCNT_W'(r_rows_m1));
        ctrl.mleft     = (ocol == '0);
        ctrl.mright    = (ocol == r_cols_m1);
        ctrl.frame_end = ctrl.mbot && ctrl.mright;
        ctrl.row       = c3zp_pkg::OUT_ROW_W'(orow);
        ctrl.col       = c3zp_pkg::OUT_COL_W'(ocol);
    end

    // Frame sizes are clamped to their legal ranges when written.
    always_comb begin
        cfg_cols = i_cfg_data[c3zp_pkg::COLS_REG_W-1:0];
        cfg_rows = i_cfg_data[c3zp_pkg::ROWS_REG_W-1:0];
        if (cfg_cols == '0) begin
            cols_clamped = CNT_W'(1);
        end else if (32'(cfg_cols) > MAX_COLS) begin
            cols_clamped = CNT_W'(MAX_COLS);
        end else begin
            cols_clamped = CNT_W'(cfg_cols);
        end
        if (cfg_rows == '0) begin
            rows_clamped = RCNT_W'(1);
        end else if (32'(cfg_rows) > c3zp_pkg::ROW_LIMIT) begin
            rows_clamped = RCNT_W'(c3zp_pkg::ROW_LIMIT);
        end else begin
            rows_clamped = RCNT_W'(cfg_rows);
        end
    end

    // Configuration writes and frame counters.
    always_comb begin
        n_cols    = r_cols;
        n_cols_m1 = r_cols_m1;
        n_rows    = r_rows;
        n_rows_m1 = r_rows_m1;
        for (int k = 0; k < KSIZE; k++) begin
            n_krow[k] = r_krow[k];
        end
        n_ir = r_ir;
        n_ic = r_ic;
        if (accept && active) begin
            if (emit && ctrl.frame_end) begin
                n_ir = '0;
                n_ic = '0;
            end else if (CNT_W'(r_ic) + CNT_W'(1) == r_cols) begin
                n_ic = '0;
                n_ir = r_ir + RCNT_W'(1);
            end else begin
                n_ic = r_ic + ADDR_W'(1);
            end
        end
        if (i_cfg_wr_en) begin
            case (c3zp_pkg::t_reg_idx'(i_cfg_index))
                c3zp_pkg::REG_FRAME_COLS: begin
                    n_cols    = cols_clamped;
                    n_cols_m1 = ADDR_W'(cols_clamped - CNT_W'(1));
                    n_ir      = '0;
                    n_ic      = '0;
                end
                c3zp_pkg::REG_FRAME_ROWS: begin
                    n_rows    = rows_clamped;
                    n_rows_m1 = c3zp_pkg::OUT_ROW_W'(rows_clamped - RCNT_W'(1));
                    n_ir      = '0;
                    n_ic      = '0;
                end
                c3zp_pkg::REG_KERNEL_TOP: begin
                    n_krow[0] = i_cfg_data[c3zp_pkg::KROW_W-1:0];
                end
                c3zp_pkg::REG_KERNEL_MID: begin
                    n_krow[1] = i_cfg_data[c3zp_pkg::KROW_W-1:0];
                end
                c3zp_pkg::REG_KERNEL_BOTTOM: begin
                    n_krow[2] = i_cfg_data[c3zp_pkg::KROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= CNT_W'(COLS_RST);
            r_cols_m1 <= ADDR_W'(COLS_RST - 1);
            r_rows    <= RCNT_W'(c3zp_pkg::FRAME_ROWS_RST);
            r_rows_m1 <= c3zp_pkg::OUT_ROW_W'(c3zp_pkg::FRAME_ROWS_RST - 1);
            for (int k = 0; k < KSIZE; k++) begin
                r_krow[k] <= '0;
            end
            r_ir <= '0;
            r_ic <= '0;
        end else begin
            r_cols    <= n_cols;
            r_cols_m1 <= n_cols_m1;
            r_rows    <= n_rows;
            r_rows_m1 <= n_rows_m1;
            for (int k = 0; k < KSIZE; k++) begin
                r_krow[k] <= n_krow[k];
            end
            r_ir <= n_ir;
            r_ic <= n_ic;
        end
    end

    // Line stores: read at the accepted column, written back next cycle.
    c3zp_lines #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept && active),
        .i_addr  (r_ic),
        .i_pixel (px_eff),
        .o_valid (ln_valid),
        .o_top   (ln_top),
        .o_mid   (ln_mid),
        .o_pixel (ln_px)
    );

    // Result control follows the window through its stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_ev[s] <= 1'b0;
            end
        end else begin
            r_ev[0] <= accept && active && emit;
            for (int s = 1; s < STAGES; s++) begin
                r_ev[s] <= r_ev[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl[0] <= ctrl;
        for (int s = 1; s < STAGES; s++) begin
            r_ctrl[s] <= r_ctrl[s-1];
        end
    end

    // Window: the newest column enters the right cell and moves left.
    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            krow_ext[k] = KEXT_W'(r_krow[k]);
        end
    end

    genvar kc;
    generate
        for (kc = 0; kc < KSIZE; kc++) begin : g_cell
            logic [KSIZE-1:0][WEIGHT_BITS-1:0] weights;
            c3zp_pkg::t_cell_mask              cmask;

            always_comb begin
                for (int kr = 0; kr < KSIZE; kr++) begin
                    weights[kr] = krow_ext[kr][kc*WEIGHT_BITS +: WEIGHT_BITS];
                end
                cmask.mtop = r_ctrl[1].mtop;
                cmask.mbot = r_ctrl[1].mbot;
                if (kc == 0) begin
                    cmask.mcol = r_ctrl[1].mleft;
                end else if (kc == KSIZE - 1) begin
                    cmask.mcol = r_ctrl[1].mright;
                end else begin
                    cmask.mcol = 1'b0;
                end
            end

            if (kc == KSIZE - 1) begin : g_newest
                assign cell_in[kc] = {ln_px, ln_mid, ln_top};
            end else begin : g_older
                assign cell_in[kc] = cell_out[kc+1];
            end

            c3zp_cell #(
                .PIXEL_BITS  (PIXEL_BITS),
                .WEIGHT_BITS (WEIGHT_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (ln_valid),
                .i_col    (cell_in[kc]),
                .i_weight (weights),
                .i_mask   (cmask),
                .o_col    (cell_out[kc]),
                .o_sum    (cell_sum[kc])
            );
        end
    endgenerate

    // Final sum of the three column sums.
    always_comb begin
        total = '0;
        for (int k = 0; k < KSIZE; k++) begin
            total = total + SUM_W'(cell_sum[k]);
        end
        result.response  = c3zp_pkg::RESP_W'(total);
        result.row       = r_ctrl[STAGES-1].row;
        result.col       = r_ctrl[STAGES-1].col;
        result.frame_end = r_ctrl[STAGES-1].frame_end;
    end

    c3zp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_ev[STAGES-1]),
        .i_data  (result),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // Stall input when queued plus in-flight results would fill the queue.
    always_comb begin
        inflight = '0;
        for (int s = 0; s < STAGES; s++) begin
            inflight = inflight + OCC_W'(r_ev[s]);
        end
        occupancy = OCC_W'(q_count) + inflight;
    end

    assign o_stall     = (occupancy >= OCC_W'(c3zp_pkg::OFIFO_DEPTH));
    assign o_response  = q_data.response;
    assign o_out_row   = q_data.row;
    assign o_out_col   = q_data.col;
    assign o_frame_end = q_data.frame_end;

endmodule
